// ===== src/mpk_pkg.sv =====
// ----------------------------------------------------------------------------
// mpk_pkg
// Types and constants shared by the k-transaction profit tracker.
// ----------------------------------------------------------------------------
package mpk_pkg;

  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 32;
  localparam int HOLD_W   = 34;
  localparam int SUM_W    = 35;
  localparam int CFG_W    = 5;

  localparam logic [CFG_W-1:0]           TRANS_RST  = 5'd2;
  localparam logic signed [HOLD_W-1:0]   HOLD_MIN   = {1'b1, {(HOLD_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]    PROFIT_MAX = {{(SUM_W-PROFIT_W){1'b0}},
                                                       {PROFIT_W{1'b1}}};

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last_day;
  } in_beat_t;

  typedef struct packed {
    logic [PROFIT_W-1:0] best_profit;
    logic                is_final;
  } out_beat_t;

  // per-beat control broadcast along the cell row
  typedef struct packed {
    logic en;
    logic clr;
  } cell_ctl_t;

endpackage

// ===== src/mpk_cell.sv =====
// ----------------------------------------------------------------------------
// mpk_cell
// One transaction lane: flat profit and holding balance for one count.
// ----------------------------------------------------------------------------
module mpk_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mpk_pkg::cell_ctl_t                  ctl,
  input  logic [mpk_pkg::PRICE_W-1:0]         price,
  input  logic [mpk_pkg::PROFIT_W-1:0]        below,
  output logic [mpk_pkg::PROFIT_W-1:0]        profit_o,
  output logic [mpk_pkg::PROFIT_W-1:0]        profit_nxt_o
);

  logic [mpk_pkg::PROFIT_W-1:0]       profit_r, profit_nxt;
  logic signed [mpk_pkg::HOLD_W-1:0]  hold_r, hold_nxt;
  logic signed [mpk_pkg::SUM_W-1:0]   sell, sell_clip, buy, price_s, profit_s, hold_s;
  logic [mpk_pkg::PROFIT_W-1:0]       profit_upd;
  logic signed [mpk_pkg::HOLD_W-1:0]  hold_upd;

  always_comb begin
    price_s  = $signed({{(mpk_pkg::SUM_W-mpk_pkg::PRICE_W){1'b0}}, price});
    profit_s = $signed({{(mpk_pkg::SUM_W-mpk_pkg::PROFIT_W){1'b0}}, profit_r});
    hold_s   = $signed({hold_r[mpk_pkg::HOLD_W-1], hold_r});
    sell     = hold_s + price_s;
    sell_clip = (sell > mpk_pkg::PROFIT_MAX) ? mpk_pkg::PROFIT_MAX : sell;
    // neighbour's profit is still the value from before this price
    buy      = $signed({{(mpk_pkg::SUM_W-mpk_pkg::PROFIT_W){1'b0}}, below}) - price_s;

    profit_upd = (sell_clip > profit_s) ? sell_clip[mpk_pkg::PROFIT_W-1:0] : profit_r;
    hold_upd   = (buy > hold_s) ? buy[mpk_pkg::HOLD_W-1:0] : hold_r;

    profit_nxt_o = profit_upd;
    profit_nxt   = profit_r;
    hold_nxt     = hold_r;
    if (ctl.en) begin
      if (ctl.clr) begin
        profit_nxt = '0;
        hold_nxt   = mpk_pkg::HOLD_MIN;
      end else begin
        profit_nxt = profit_upd;
        hold_nxt   = hold_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      profit_r <= '0;
      hold_r   <= mpk_pkg::HOLD_MIN;
    end else begin
      profit_r <= profit_nxt;
      hold_r   <= hold_nxt;
    end
  end

  assign profit_o = profit_r;

endmodule

// ===== src/max_profit_k_transactions_top.sv =====
// ----------------------------------------------------------------------------
// max_profit_k_transactions_top
// Best profit over at most k buy/sell pairs, one lane cell per pair count.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in_     | in_valid / in_stall  | mpk_pkg::in_beat_t  (price, last_day)
//  out_    | out_valid / out_stall| mpk_pkg::out_beat_t (best_profit, is_final)
//  cfg_    | cfg_valid / cfg_ready| cfg_data: transactions (5 bits)
//
// One price beat per cycle while the input is not stalled: every lane cell
// updates at the accept edge from its neighbour's registered profit, and the
// result lands in the output register on that same edge.
// Reset (rst_n low, synchronous) clears all lanes and sets transactions to 2.
// A stalled result stalls the input only while the output register is full.
// ----------------------------------------------------------------------------
module max_profit_k_transactions_top #(
  parameter int MAX_TRANSACTIONS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mpk_pkg::in_beat_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mpk_pkg::out_beat_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpk_pkg::CFG_W-1:0]      cfg_data
);

  localparam int KW = $clog2(MAX_TRANSACTIONS + 1);

  logic [mpk_pkg::CFG_W-1:0]    trans_r, trans_nxt;
  logic                         out_valid_r, out_valid_nxt;
  mpk_pkg::out_beat_t           out_data_r, out_data_nxt;
  logic                         accept;
  mpk_pkg::cell_ctl_t           ctl;
  logic [KW-1:0]                k;
  logic [mpk_pkg::PROFIT_W-1:0] best;

  logic [mpk_pkg::PROFIT_W-1:0] profit [MAX_TRANSACTIONS];
  logic [mpk_pkg::PROFIT_W-1:0] profit_nxt [MAX_TRANSACTIONS];

  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;
  assign ctl.en    = accept;
  assign ctl.clr   = in_data.last_day;

  genvar g;
  generate
    for (g = 0; g < MAX_TRANSACTIONS; g++) begin : g_lane
      if (g == 0) begin : g_first
        mpk_cell u_cell (
          .clk          (clk),
          .rst_n        (rst_n),
          .ctl          (ctl),
          .price        (in_data.price),
          .below        ('0),
          .profit_o     (profit[g]),
          .profit_nxt_o (profit_nxt[g])
        );
      end else begin : g_rest
        mpk_cell u_cell (
          .clk          (clk),
          .rst_n        (rst_n),
          .ctl          (ctl),
          .price        (in_data.price),
          .below        (profit[g-1]),
          .profit_o     (profit[g]),
          .profit_nxt_o (profit_nxt[g])
        );
      end
    end
  endgenerate

  // transaction count clamped to the lane count; zero picks no lane
  always_comb begin
    if ({2'b00, trans_r} > 7'(MAX_TRANSACTIONS)) begin
      k = KW'(MAX_TRANSACTIONS);
    end else begin
      k = KW'(trans_r);
    end
    best = '0;
    for (int i = 0; i < MAX_TRANSACTIONS; i++) begin
      if (k == KW'(i + 1)) begin
        best = profit_nxt[i];
      end
    end
  end

  always_comb begin
    trans_nxt     = cfg_valid ? cfg_data : trans_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.best_profit = best;
      out_data_nxt.is_final    = in_data.last_day;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_r     <= mpk_pkg::TRANS_RST;
      out_valid_r <= 1'b0;
    end else begin
      trans_r     <= trans_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/mpk_checker.sv =====
// ----------------------------------------------------------------------------
// mpk_checker
// Port-level checks on the profit tracker, bound to the top level.
// ----------------------------------------------------------------------------
module mpk_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input mpk_pkg::in_beat_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input mpk_pkg::out_beat_t  out_data
);

  // every accepted beat gives a result on the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted beat produced no result");

  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_data.is_final == $past(in_data.last_day))
    else $error("is_final does not follow last_day");

  // input only backs up when a held result is stalled
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall without a blocked result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind max_profit_k_transactions_top mpk_checker u_mpk_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
